### rtl/pts_pkg.sv
// pts_pkg: shared constants, codes and control types for the task scheduler
// used by pts_ctrl, pts_dp and priority_task_scheduler_semaphores
// no dependencies
package pts_pkg;

	// default sizes
	localparam int NUM_TASKS_DEF      = 4;
	localparam int NUM_SEMS_DEF       = 2;
	localparam int PRIORITY_LIMIT_DEF = 100;

	// command codes on func
	localparam logic [2:0] FN_SCHED  = 3'd0;
	localparam logic [2:0] FN_WAIT   = 3'd1;
	localparam logic [2:0] FN_SIGNAL = 3'd2;
	localparam logic [2:0] FN_SLICE  = 3'd3;
	localparam logic [2:0] FN_FINISH = 3'd4;
	localparam logic [2:0] FN_LOAD   = 3'd5;

	// task record states
	localparam logic [2:0] TS_DONE    = 3'd0;
	localparam logic [2:0] TS_READY_H = 3'd1;
	localparam logic [2:0] TS_READY_L = 3'd2;
	localparam logic [2:0] TS_WAITING = 3'd3;
	localparam logic [2:0] TS_RUNNING = 3'd4;

	// result status codes
	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_BLOCKED  = 3'd1;
	localparam logic [2:0] STS_WOKEN    = 3'd2;
	localparam logic [2:0] STS_NONE_RDY = 3'd3;
	localparam logic [2:0] STS_NO_RUN   = 3'd4;

	// block count that triggers a boost to priority zero
	localparam logic [1:0] BOOST_AT = 2'd3;

	// semaphore count limits and reset values
	localparam logic signed [3:0] SEM_MIN      = -4'sd8;
	localparam logic signed [3:0] SEM_MAX      = 4'sd7;
	localparam logic signed [3:0] SEM_RST      = 4'sd1;
	localparam logic [2:0]        SEM_INIT_RST = 3'd1;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic scan;
		logic exec;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_last;
	} ctl_sts_t;

endpackage

### rtl/pts_ctrl.sv
// pts_ctrl: command sequencer of the task scheduler
// depends on pts_pkg
module pts_ctrl
	import pts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] func,
	input  ctl_sts_t   sts,
	output ctl_cmd_t   cmd,
	output logic       busy,
	output logic       done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.scan    = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = (func == FN_SCHED) ? S_SCAN : S_EXEC;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

### rtl/pts_dp.sv
// pts_dp: task records, semaphores, wait lists, pick scan and command execution
// depends on pts_pkg
module pts_dp
	import pts_pkg::*;
#(
	parameter int NUM_TASKS      = NUM_TASKS_DEF,
	parameter int NUM_SEMS       = NUM_SEMS_DEF,
	parameter int PRIORITY_LIMIT = PRIORITY_LIMIT_DEF,
	localparam int TW = $clog2(NUM_TASKS),
	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1
)
(
	input  logic          clk,
	input  logic          arst_n,
	input  ctl_cmd_t      cmd,
	output ctl_sts_t      sts,
	input  logic [2:0]    func,
	input  logic [TW-1:0] task_index,
	input  logic [SW-1:0] sem_index,
	input  logic [7:0]    priority_req,
	output logic [TW-1:0] running_task,
	output logic          running_valid,
	output logic [2:0]    status,
	output logic [TW-1:0] woken_task,
	output logic          woken_valid,
	output logic          boosted
);

	// captured command
	logic [2:0]    func_q;
	logic [TW-1:0] tix_q;
	logic [SW-1:0] six_q;
	logic [7:0]    preq_q;

	// task records
	logic [2:0]    st_q     [NUM_TASKS];
	logic [7:0]    pr_q     [NUM_TASKS];
	logic [1:0]    bc_q     [NUM_TASKS];
	logic [TW-1:0] nw_q     [NUM_TASKS];
	logic          nw_vld_q [NUM_TASKS];

	// semaphores
	logic signed [3:0] cnt_q      [NUM_SEMS];
	logic [TW-1:0]     head_q     [NUM_SEMS];
	logic              head_vld_q [NUM_SEMS];
	logic [TW-1:0]     tail_q     [NUM_SEMS];

	// running task
	logic [TW-1:0] cur_q;
	logic          cur_vld_q;

	// scan state
	logic [TW-1:0] idx_q;
	logic [7:0]    cur_pr_q;
	logic [TW-1:0] bh_q, bl_q;
	logic [7:0]    bh_pr_q, bl_pr_q;
	logic [1:0]    bh_bc_q, bl_bc_q;
	logic          bh_vld_q, bl_vld_q;

	// results
	logic [2:0]    status_q;
	logic [TW-1:0] woken_q;
	logic          woken_vld_q;
	logic          boost_q;

	// combinational
	logic              sem_ok, tix_ok;
	logic [TW-1:0]     raddr;
	logic [2:0]        rd_st;
	logic [7:0]        rd_pr;
	logic [1:0]        rd_bc;
	logic [TW-1:0]     rd_nw;
	logic              rd_nw_vld;
	logic              h_hit, l_hit;
	logic              pv;
	logic [TW-1:0]     pd;
	logic [7:0]        pd_pr;
	logic [1:0]        pd_bc;
	logic signed [3:0] cnt_cur, cnt_dn, cnt_up;
	logic [TW-1:0]     head_cur, tail_cur;
	logic              head_vld_cur;

	assign sem_ok = (int'(six_q) < NUM_SEMS);
	assign tix_ok = (int'(tix_q) < NUM_TASKS);

	// semaphore selected by the command
	always_comb begin
		cnt_cur      = SEM_RST;
		head_cur     = '0;
		tail_cur     = '0;
		head_vld_cur = 1'b0;
		if (sem_ok) begin
			cnt_cur      = cnt_q[six_q];
			head_cur     = head_q[six_q];
			tail_cur     = tail_q[six_q];
			head_vld_cur = head_vld_q[six_q];
		end
	end

	assign cnt_dn = (cnt_cur != SEM_MIN) ? cnt_cur - 4'sd1 : cnt_cur;
	assign cnt_up = (cnt_cur != SEM_MAX) ? cnt_cur + 4'sd1 : cnt_cur;

	// single read port into the task records
	always_comb begin
		case (func_q)
			FN_SCHED:  raddr = idx_q;
			FN_WAIT:   raddr = cur_q;
			FN_SIGNAL: raddr = head_cur;
			default:   raddr = tix_q;
		endcase
	end

	always_comb begin
		rd_st     = TS_DONE;
		rd_pr     = '0;
		rd_bc     = '0;
		rd_nw     = '0;
		rd_nw_vld = 1'b0;
		if (int'(raddr) < NUM_TASKS) begin
			rd_st     = st_q[raddr];
			rd_pr     = pr_q[raddr];
			rd_bc     = bc_q[raddr];
			rd_nw     = nw_q[raddr];
			rd_nw_vld = nw_vld_q[raddr];
		end
	end

	// scan compare: strict less keeps the lowest index on a tie
	assign h_hit = (rd_st == TS_READY_H) && (rd_pr < bh_pr_q);
	assign l_hit = (rd_st == TS_READY_L) && (rd_pr < bl_pr_q);
	assign sts.scan_last = (idx_q == TW'(NUM_TASKS - 1));

	// pick: best ready-high, else best ready-low
	assign pv    = bh_vld_q || bl_vld_q;
	assign pd    = bh_vld_q ? bh_q    : bl_q;
	assign pd_pr = bh_vld_q ? bh_pr_q : bl_pr_q;
	assign pd_bc = bh_vld_q ? bh_bc_q : bl_bc_q;

	// command capture and pick scan
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= func;
			tix_q    <= task_index;
			six_q    <= sem_index;
			preq_q   <= priority_req;
			idx_q    <= '0;
			bh_vld_q <= 1'b0;
			bl_vld_q <= 1'b0;
			bh_pr_q  <= 8'(PRIORITY_LIMIT);
			bl_pr_q  <= 8'(PRIORITY_LIMIT);
		end else if (cmd.scan) begin
			idx_q <= idx_q + TW'(1);
			if (h_hit) begin
				bh_q     <= idx_q;
				bh_pr_q  <= rd_pr;
				bh_bc_q  <= rd_bc;
				bh_vld_q <= 1'b1;
			end
			if (l_hit) begin
				bl_q     <= idx_q;
				bl_pr_q  <= rd_pr;
				bl_bc_q  <= rd_bc;
				bl_vld_q <= 1'b1;
			end
			if (cur_vld_q && (idx_q == cur_q)) begin
				cur_pr_q <= rd_pr;
			end
		end
	end

	// command execution on the scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				st_q[i]     <= TS_DONE;
				pr_q[i]     <= '0;
				bc_q[i]     <= '0;
				nw_q[i]     <= '0;
				nw_vld_q[i] <= 1'b0;
			end
			for (int s = 0; s < NUM_SEMS; s++) begin
				cnt_q[s]      <= SEM_RST;
				head_q[s]     <= '0;
				head_vld_q[s] <= 1'b0;
				tail_q[s]     <= '0;
			end
			cur_q       <= '0;
			cur_vld_q   <= 1'b0;
			status_q    <= STS_OK;
			woken_q     <= '0;
			woken_vld_q <= 1'b0;
			boost_q     <= 1'b0;
		end else if (cmd.exec) begin
			status_q    <= STS_OK;
			woken_q     <= '0;
			woken_vld_q <= 1'b0;
			boost_q     <= 1'b0;
			case (func_q)
				FN_SCHED: begin
					if (!pv) begin
						if (!cur_vld_q) begin
							status_q <= STS_NONE_RDY;
						end
					end else begin
						if (!cur_vld_q) begin
							st_q[pd]  <= TS_RUNNING;
							cur_q     <= pd;
							cur_vld_q <= 1'b1;
						end else if (pd_pr < cur_pr_q) begin
							st_q[cur_q] <= TS_READY_H;
							st_q[pd]    <= TS_RUNNING;
							cur_q       <= pd;
						end
						// boost applies to any valid pick
						if (pd_bc == BOOST_AT) begin
							bc_q[pd] <= '0;
							pr_q[pd] <= '0;
							boost_q  <= 1'b1;
						end
					end
				end
				FN_WAIT: begin
					if (sem_ok) begin
						if (!cur_vld_q) begin
							status_q <= STS_NO_RUN;
						end else begin
							cnt_q[six_q] <= cnt_dn;
							// count went negative: block onto the wait list tail
							if (cnt_dn[3]) begin
								st_q[cur_q]     <= TS_WAITING;
								nw_vld_q[cur_q] <= 1'b0;
								if (rd_bc != BOOST_AT) begin
									bc_q[cur_q] <= rd_bc + 2'd1;
								end
								if (head_vld_cur) begin
									nw_q[tail_cur]     <= cur_q;
									nw_vld_q[tail_cur] <= 1'b1;
								end else begin
									head_q[six_q]     <= cur_q;
									head_vld_q[six_q] <= 1'b1;
								end
								tail_q[six_q] <= cur_q;
								cur_vld_q     <= 1'b0;
								status_q      <= STS_BLOCKED;
							end
						end
					end
				end
				FN_SIGNAL: begin
					if (sem_ok) begin
						cnt_q[six_q] <= cnt_up;
						// count still not positive: wake the head waiter
						if ((cnt_up[3] || (cnt_up == 4'sd0)) && head_vld_cur) begin
							head_q[six_q]     <= rd_nw;
							head_vld_q[six_q] <= rd_nw_vld;
							nw_vld_q[raddr]   <= 1'b0;
							st_q[raddr]       <= TS_READY_H;
							woken_q           <= raddr;
							woken_vld_q       <= 1'b1;
							status_q          <= STS_WOKEN;
						end
					end
				end
				FN_SLICE, FN_FINISH: begin
					if (!cur_vld_q) begin
						status_q <= STS_NO_RUN;
					end else begin
						st_q[cur_q] <= (func_q == FN_SLICE) ? TS_READY_L : TS_DONE;
						cur_vld_q   <= 1'b0;
					end
				end
				FN_LOAD: begin
					if (tix_ok && (rd_st != TS_RUNNING) && (rd_st != TS_WAITING)) begin
						st_q[tix_q]     <= TS_READY_H;
						pr_q[tix_q]     <= preq_q;
						bc_q[tix_q]     <= '0;
						nw_vld_q[tix_q] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign running_task  = cur_vld_q ? cur_q : '0;
	assign running_valid = cur_vld_q;
	assign status        = status_q;
	assign woken_task    = woken_q;
	assign woken_valid   = woken_vld_q;
	assign boosted       = boost_q;

endmodule

### rtl/priority_task_scheduler_semaphores.sv
// priority_task_scheduler_semaphores: top level of the hardware task scheduler
// depends on pts_pkg, pts_ctrl and pts_dp
//
// A command is taken when start is high and busy is low. Schedule scans the
// task records one per cycle, then enters the execute state; other commands
// enter it straight from accept. done, registered from it, is high for a
// single cycle with the result on the result ports and cannot be held off
// by the receiver; busy is already low in that cycle, so the next command
// may be issued there. running_task and running_valid keep showing the
// current running task between commands. After reset every semaphore count
// is 1, the reset value of sem_initial; a write to sem_initial is held in
// the register and does not change the live counts. No clearing pass.
module priority_task_scheduler_semaphores
	import pts_pkg::*;
#(
	parameter int NUM_TASKS      = NUM_TASKS_DEF,
	parameter int NUM_SEMS       = NUM_SEMS_DEF,
	parameter int PRIORITY_LIMIT = PRIORITY_LIMIT_DEF,
	localparam int TW = $clog2(NUM_TASKS),
	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1
)
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [2:0]    func,
	input  logic [TW-1:0] task_index,
	input  logic [SW-1:0] sem_index,
	input  logic [7:0]    priority_req,
	output logic          done,
	output logic [TW-1:0] running_task,
	output logic          running_valid,
	output logic [2:0]    status,
	output logic [TW-1:0] woken_task,
	output logic          woken_valid,
	output logic          boosted,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_wdata
);

	ctl_cmd_t   cmd;
	ctl_sts_t   sts;
	logic [2:0] sem_initial_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sem_initial_q <= SEM_INIT_RST;
		end else if (cfg_we) begin
			sem_initial_q <= cfg_wdata;
		end
	end

	// command sequencer
	pts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// scheduler state and execution
	pts_dp #(
		.NUM_TASKS      (NUM_TASKS),
		.NUM_SEMS       (NUM_SEMS),
		.PRIORITY_LIMIT (PRIORITY_LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.task_index    (task_index),
		.sem_index     (sem_index),
		.priority_req  (priority_req),
		.running_task  (running_task),
		.running_valid (running_valid),
		.status        (status),
		.woken_task    (woken_task),
		.woken_valid   (woken_valid),
		.boosted       (boosted)
	);

	// an accepted transaction always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// a blocked running task leaves the processor idle
	a_block_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STS_BLOCKED)) |-> !running_valid)
		else $error("running task still valid after blocking");

	// a woken task is reported exactly with the woken status
	a_woken_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (woken_valid == (status == STS_WOKEN)))
		else $error("woken_valid disagrees with status");

	// a boost comes only from a schedule that leaves a task running
	a_boost_run: assert property (@(posedge clk) disable iff (!arst_n)
		(done && boosted) |-> (running_valid && (status == STS_OK)))
		else $error("boost reported without a running task");

	// the configuration register changes only on a write
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(sem_initial_q))
		else $error("sem_initial changed without a write");

endmodule

### dv/pts_sched_checker.sv
// pts_sched_checker: watches the command and result channels of the task scheduler,
// keeps its own copy of the task records and semaphores and checks every result
// depends on pts_pkg
module pts_sched_checker
	import pts_pkg::*;
#(
	parameter int NT   = NUM_TASKS_DEF,
	parameter int NS   = NUM_SEMS_DEF,
	parameter int PLIM = PRIORITY_LIMIT_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [2:0] func,
	input  logic [1:0] task_index,
	input  logic       sem_index,
	input  logic [7:0] priority_req,
	input  logic       done,
	input  logic [1:0] running_task,
	input  logic       running_valid,
	input  logic [2:0] status,
	input  logic [1:0] woken_task,
	input  logic       woken_valid,
	input  logic       boosted,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	output int         fail_count,
	output int         pending,
	output int         checked_count,
	output int         boost_count,
	output int         wake_count,
	output int         block_count,
	output int         sat_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] NIL = 3'd7;

	typedef struct packed {
		logic [1:0] run_task;
		logic       run_ok;
		logic [2:0] status;
		logic [1:0] woke_task;
		logic       woke_ok;
		logic       boost;
	} sched_result_t;

	// mirrored scheduler state
	logic [2:0]        tstate   [NT];
	logic [7:0]        tprio    [NT];
	logic [1:0]        nblk     [NT];
	logic [2:0]        link     [NT];
	logic signed [3:0] sem_cnt  [NS];
	logic [2:0]        sem_head [NS];
	logic [2:0]        cur;
	logic [2:0]        sem_init_reg;

	sched_result_t results_due[$];
	int n_fail, n_checked, n_boost, n_wake, n_block, n_sat;

	// one line per mismatch
	task automatic flag(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		n_fail++;
	endtask

	// best task in the wanted state with priority number under the limit
	function automatic logic [2:0] best_ready(input logic [2:0] want);
		logic [2:0] best;
		logic [7:0] lim;
		best = NIL;
		lim = 8'(PLIM);
		for (int t = 0; t < NT; t++) begin
			if (tstate[t] == want && tprio[t] < lim) begin
				lim = tprio[t];
				best = 3'(t);
			end
		end
		return best;
	endfunction

	// apply one command to the mirrored state and work out its result
	task automatic advance_scheduler(input logic [2:0] fn, input logic [1:0] ti,
			input logic si, input logic [7:0] pr, output sched_result_t r);
		logic [2:0] pick;
		logic [2:0] tail;
		logic       running;
		running = (cur != NIL);
		r = '0;
		case (fn)
			FN_SCHED: begin
				pick = best_ready(TS_READY_H);
				if (pick == NIL)
					pick = best_ready(TS_READY_L);
				if (pick == NIL) begin
					if (!running)
						r.status = STS_NONE_RDY;
				end else begin
					if (!running) begin
						tstate[pick] = TS_RUNNING;
						cur = pick;
					end else if (tprio[pick] < tprio[cur]) begin
						tstate[cur] = TS_READY_H;
						tstate[pick] = TS_RUNNING;
						cur = pick;
					end
					// boost applies to the pick even when it does not preempt
					if (nblk[pick] == BOOST_AT) begin
						nblk[pick] = 2'd0;
						tprio[pick] = 8'd0;
						r.boost = 1'b1;
						n_boost++;
					end
				end
			end
			FN_WAIT: begin
				if (!running) begin
					r.status = STS_NO_RUN;
				end else begin
					if (sem_cnt[si] != SEM_MIN)
						sem_cnt[si] = sem_cnt[si] - 4'sd1;
					if (sem_cnt[si] < 0) begin
						// block the running task at the tail of the wait list
						tstate[cur] = TS_WAITING;
						if (nblk[cur] != BOOST_AT)
							nblk[cur] = nblk[cur] + 2'd1;
						link[cur] = NIL;
						if (sem_head[si] == NIL) begin
							sem_head[si] = cur;
						end else begin
							tail = sem_head[si];
							for (int g = 0; g < NT && link[tail] != NIL; g++)
								tail = link[tail];
							link[tail] = cur;
						end
						cur = NIL;
						r.status = STS_BLOCKED;
						n_block++;
					end
				end
			end
			FN_SIGNAL: begin
				if (sem_cnt[si] != SEM_MAX)
					sem_cnt[si] = sem_cnt[si] + 4'sd1;
				else
					n_sat++;
				// wake the head waiter while the count is still not positive
				if (sem_cnt[si] <= 0 && sem_head[si] != NIL) begin
					pick = sem_head[si];
					sem_head[si] = link[pick];
					link[pick] = NIL;
					tstate[pick] = TS_READY_H;
					r.woke_task = pick[1:0];
					r.woke_ok = 1'b1;
					r.status = STS_WOKEN;
					n_wake++;
				end
			end
			FN_SLICE, FN_FINISH: begin
				if (!running) begin
					r.status = STS_NO_RUN;
				end else begin
					tstate[cur] = (fn == FN_SLICE) ? TS_READY_L : TS_DONE;
					cur = NIL;
				end
			end
			FN_LOAD: begin
				// running and waiting tasks cannot be reloaded
				if (tstate[ti] != TS_RUNNING && tstate[ti] != TS_WAITING) begin
					tstate[ti] = TS_READY_H;
					tprio[ti] = pr;
					nblk[ti] = 2'd0;
					link[ti] = NIL;
				end
			end
			default: ;
		endcase
		if (cur != NIL) begin
			r.run_task = cur[1:0];
			r.run_ok = 1'b1;
		end
	endtask

	// watch both channels, predict on accept and compare on the done strobe
	always @(posedge clk or negedge arst_n) begin
		sched_result_t got_r;
		sched_result_t want_r;
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) begin
				tstate[t] = TS_DONE;
				tprio[t] = 8'd0;
				nblk[t] = 2'd0;
				link[t] = NIL;
			end
			// live counts always restart from the reset value, not from the register
			for (int s = 0; s < NS; s++) begin
				sem_cnt[s] = SEM_RST;
				sem_head[s] = NIL;
			end
			cur = NIL;
			sem_init_reg = SEM_INIT_RST;
			results_due.delete();
			n_fail = 0;
			n_checked = 0;
			n_boost = 0;
			n_wake = 0;
			n_block = 0;
			n_sat = 0;
		end else begin
			if (cfg_we)
				sem_init_reg = cfg_wdata;
			if (done) begin
				if (results_due.size() == 0) begin
					flag("result strobe with no command outstanding");
				end else begin
					want_r = results_due.pop_front();
					n_checked++;
					if (running_task !== want_r.run_task)
						flag($sformatf("running_task got %0d want %0d",
							running_task, want_r.run_task));
					if (running_valid !== want_r.run_ok)
						flag($sformatf("running_valid got %0d want %0d",
							running_valid, want_r.run_ok));
					if (status !== want_r.status)
						flag($sformatf("status got %0d want %0d", status, want_r.status));
					if (woken_task !== want_r.woke_task)
						flag($sformatf("woken_task got %0d want %0d",
							woken_task, want_r.woke_task));
					if (woken_valid !== want_r.woke_ok)
						flag($sformatf("woken_valid got %0d want %0d",
							woken_valid, want_r.woke_ok));
					if (boosted !== want_r.boost)
						flag($sformatf("boosted got %0d want %0d", boosted, want_r.boost));
				end
			end
			if (start && !busy) begin
				advance_scheduler(func, task_index, sem_index, priority_req, got_r);
				results_due.push_back(got_r);
			end
		end
		fail_count    <= n_fail;
		pending       <= results_due.size();
		checked_count <= n_checked;
		boost_count   <= n_boost;
		wake_count    <= n_wake;
		block_count   <= n_block;
		sat_count     <= n_sat;
	end

endmodule

### dv/priority_task_scheduler_semaphores_test.sv
// priority_task_scheduler_semaphores_test: drives scheduler commands and
// sem_initial writes, and gives the verdict from the checker's failure count
// depends on pts_pkg, pts_sched_checker and priority_task_scheduler_semaphores
module priority_task_scheduler_semaphores_test
	import pts_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FN_NOP6   = 3'd6;
	localparam logic [2:0] FN_NOP7   = 3'd7;
	localparam int         PHASE_LEN = 410;
	localparam int         WATCHDOG  = 400;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] func;
	logic [1:0] task_index;
	logic       sem_index;
	logic [7:0] priority_req;
	logic       done;
	logic [1:0] running_task;
	logic       running_valid;
	logic [2:0] status;
	logic [1:0] woken_task;
	logic       woken_valid;
	logic       boosted;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	int fail_count, pending, checked_count, boost_count, wake_count, block_count, sat_count;
	int n_sent;
	int idle_cycles;

	always #6 clk = ~clk;

	priority_task_scheduler_semaphores dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.task_index   (task_index),
		.sem_index    (sem_index),
		.priority_req (priority_req),
		.done         (done),
		.running_task (running_task),
		.running_valid(running_valid),
		.status       (status),
		.woken_task   (woken_task),
		.woken_valid  (woken_valid),
		.boosted      (boosted),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	pts_sched_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.task_index   (task_index),
		.sem_index    (sem_index),
		.priority_req (priority_req),
		.done         (done),
		.running_task (running_task),
		.running_valid(running_valid),
		.status       (status),
		.woken_task   (woken_task),
		.woken_valid  (woken_valid),
		.boosted      (boosted),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked_count(checked_count),
		.boost_count  (boost_count),
		.wake_count   (wake_count),
		.block_count  (block_count),
		.sat_count    (sat_count)
	);

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout after %0d quiet cycles", idle_cycles);
			$display("** priority_task_scheduler_semaphores: FAILED **");
			$finish;
		end
	end

	// present one command and hold it until the block takes it
	task automatic issue(input logic [2:0] fn, input logic [1:0] ti, input logic si,
			input logic [7:0] pr);
		start <= 1'b1;
		func <= fn;
		task_index <= ti;
		sem_index <= si;
		priority_req <= pr;
		do
			@(posedge clk);
		while (busy);
		n_sent++;
	endtask

	// drop start and wait until every result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_sem_initial(input logic [2:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// priority mix: near zero, around the limit, anywhere, and the two ends
	function automatic logic [7:0] rand_priority();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 7));
			1: return 8'($urandom_range(PRIORITY_LIMIT_DEF - 5, PRIORITY_LIMIT_DEF + 4));
			2: return 8'($urandom_range(0, 255));
			default: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
		endcase
	endfunction

	function automatic logic [2:0] rand_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return FN_SCHED;
		if (r < 52) return FN_WAIT;
		if (r < 66) return FN_SIGNAL;
		if (r < 82) return FN_LOAD;
		if (r < 89) return FN_SLICE;
		if (r < 95) return FN_FINISH;
		return ($urandom_range(0, 1) != 0) ? FN_NOP7 : FN_NOP6;
	endfunction

	// one random phase, with an idle-free stretch in the middle when quiet_middle is set
	task automatic random_phase(input int count, input bit quiet_middle);
		int  gap;
		logic s;
		for (int i = 0; i < count; i++) begin
			gap = 0;
			if (!(quiet_middle && i > count / 4 && i < 3 * count / 4)
					&& $urandom_range(0, 99) < 11)
				gap = $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if ($urandom_range(0, 49) == 0) begin
				// burst of signals to drive a count into its upper limit
				s = 1'($urandom_range(0, 1));
				for (int k = 0; k < 8; k++)
					issue(FN_SIGNAL, 2'($urandom_range(0, 3)), s, rand_priority());
			end else begin
				issue(rand_func(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					rand_priority());
			end
		end
	endtask

	initial begin
		n_sent = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FN_SCHED;
		task_index <= 2'd0;
		sem_index <= 1'b0;
		priority_req <= 8'd0;
		cfg_we <= 1'b0;
		cfg_wdata <= 3'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_sem_initial(3'd4);

		// directed: commands with nothing running
		issue(FN_SCHED, 2'd0, 1'b0, 8'd0);
		issue(FN_WAIT, 2'd0, 1'b0, 8'd0);
		issue(FN_SLICE, 2'd0, 1'b0, 8'd0);
		issue(FN_FINISH, 2'd0, 1'b0, 8'd0);
		issue(FN_SIGNAL, 2'd0, 1'b0, 8'd0);
		// priorities at and around the limit, plus both ends
		issue(FN_LOAD, 2'd0, 1'b0, 8'd255);
		issue(FN_LOAD, 2'd1, 1'b0, 8'd0);
		issue(FN_LOAD, 2'd2, 1'b1, 8'd99);
		issue(FN_LOAD, 2'd3, 1'b1, 8'd100);
		issue(FN_SCHED, 2'd0, 1'b0, 8'd0);
		// waits until the running task blocks, then wake it
		issue(FN_WAIT, 2'd0, 1'b1, 8'd0);
		issue(FN_WAIT, 2'd0, 1'b1, 8'd0);
		issue(FN_SCHED, 2'd0, 1'b0, 8'd0);
		issue(FN_WAIT, 2'd0, 1'b1, 8'd0);
		issue(FN_SIGNAL, 2'd0, 1'b1, 8'd0);
		issue(FN_SCHED, 2'd0, 1'b0, 8'd0);
		// slice then reschedule from the low queue
		issue(FN_SLICE, 2'd0, 1'b0, 8'd0);
		issue(FN_SCHED, 2'd0, 1'b0, 8'd0);
		// reload of a running task and a waiting task are ignored
		issue(FN_LOAD, 2'd1, 1'b0, 8'd7);
		issue(FN_LOAD, 2'd2, 1'b0, 8'd7);
		issue(FN_FINISH, 2'd0, 1'b0, 8'd0);
		issue(FN_NOP6, 2'd3, 1'b1, 8'd255);
		issue(FN_NOP7, 2'd3, 1'b1, 8'd255);
		issue(FN_SIGNAL, 2'd0, 1'b1, 8'd0);
		issue(FN_SCHED, 2'd0, 1'b0, 8'd0);

		// random phases across register settings
		write_sem_initial(3'd0);
		random_phase(PHASE_LEN, 1'b0);
		write_sem_initial(3'd2);
		random_phase(PHASE_LEN, 1'b1);
		write_sem_initial(3'($urandom_range(0, 4)));
		random_phase(PHASE_LEN, 1'b0);
		write_sem_initial(3'd1);
		random_phase(PHASE_LEN, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		$display("sent %0d commands, checked %0d results", n_sent, checked_count);
		$display("blocks %0d, wakeups %0d, boosts %0d, signals at the count ceiling %0d",
			block_count, wake_count, boost_count, sat_count);
		if (fail_count == 0)
			$display("** priority_task_scheduler_semaphores: PASSED **");
		else
			$display("** priority_task_scheduler_semaphores: FAILED **");
		$finish;
	end

endmodule
